[design/quaternion_alu_with_rotation_top_macros.svh]
// ----------------------------------------------------------------------------
// Quaternion ALU assertion macros
// Shared concurrent assertion forms, clocked on clk and off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_ALU_WITH_ROTATION_TOP_MACROS_SVH
`define QUATERNION_ALU_WITH_ROTATION_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QAR_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define QAR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/qar_pkg.sv]
// ----------------------------------------------------------------------------
// Quaternion ALU package
// Default formats, operation codes and the Hamilton product term tables.
// ----------------------------------------------------------------------------
package qar_pkg;

	// Default component format: Q2.14.
	localparam int COMPONENT_WIDTH_DEF = 16;
	localparam int FRACTION_BITS_DEF   = 14;

	// Operation codes.
	typedef logic [2:0] op_t;
	localparam op_t OP_MUL  = 3'd0;
	localparam op_t OP_ADD  = 3'd1;
	localparam op_t OP_SUB  = 3'd2;
	localparam op_t OP_CONJ = 3'd3;
	localparam op_t OP_ROT  = 3'd4;

	// Hamilton product terms. Component order is i, j, k, real.
	// Output o sums term t = +/- a[QM_A_IDX[o][t]] * b[QM_B_IDX[o][t]].
	localparam logic [1:0] QM_A_IDX [4][4] = '{
		'{2'd3, 2'd0, 2'd1, 2'd2},
		'{2'd3, 2'd1, 2'd2, 2'd0},
		'{2'd3, 2'd2, 2'd0, 2'd1},
		'{2'd3, 2'd0, 2'd1, 2'd2}
	};
	localparam logic [1:0] QM_B_IDX [4][4] = '{
		'{2'd0, 2'd3, 2'd2, 2'd1},
		'{2'd1, 2'd3, 2'd0, 2'd2},
		'{2'd2, 2'd3, 2'd1, 2'd0},
		'{2'd3, 2'd0, 2'd1, 2'd2}
	};
	localparam logic QM_NEG [4][4] = '{
		'{1'b0, 1'b0, 1'b0, 1'b1},
		'{1'b0, 1'b0, 1'b0, 1'b1},
		'{1'b0, 1'b0, 1'b0, 1'b1},
		'{1'b0, 1'b1, 1'b1, 1'b1}
	};

endpackage

[design/qar_qmul.sv]
// ----------------------------------------------------------------------------
// Quaternion multiplier
// Three-stage Hamilton product: sixteen products, four signed sums with the
// rounding half added, then a floor shift and saturation to component width.
// ----------------------------------------------------------------------------
module qar_qmul #(
	parameter int W = qar_pkg::COMPONENT_WIDTH_DEF,
	parameter int F = qar_pkg::FRACTION_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [3:0][W-1:0]   a,
	input  logic [3:0][W-1:0]   b,
	output logic                out_valid,
	output logic [3:0][W-1:0]   q,
	output logic                sat
);
	import qar_pkg::*;

	localparam int PW = 2 * W;
	localparam int SW = 2 * W + 3;
	localparam int RW = SW - F;
	localparam logic signed [SW-1:0] HALF = {{(SW - F){1'b0}}, 1'b1, {(F - 1){1'b0}}};
	localparam logic signed [RW-1:0] SMAX = {{(RW - W + 1){1'b0}}, {(W - 1){1'b1}}};
	localparam logic signed [RW-1:0] SMIN = ~SMAX;

	logic                 v_s1, v_s2, v_s3;
	logic signed [PW-1:0] prod_s1 [4][4];
	logic signed [SW-1:0] acc [4];
	logic signed [SW-1:0] sum_s2 [4];
	logic signed [RW-1:0] shr [4];
	logic [3:0]           ovf;
	logic [3:0][W-1:0]    satv;
	logic [3:0][W-1:0]    q_s3;
	logic                 sat_s3;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 1: all sixteen full-width products.
	always_ff @(posedge clk) begin
		for (int o = 0; o < 4; o++) begin
			for (int t = 0; t < 4; t++) begin
				prod_s1[o][t] <= PW'($signed(a[QM_A_IDX[o][t]]))
					* PW'($signed(b[QM_B_IDX[o][t]]));
			end
		end
	end

	// Stage 2: exact signed sum of the four terms plus half an LSB for rounding.
	always_comb begin
		for (int o = 0; o < 4; o++) begin
			acc[o] = HALF;
			for (int t = 0; t < 4; t++) begin
				if (QM_NEG[o][t]) begin
					acc[o] = acc[o] - SW'(prod_s1[o][t]);
				end else begin
					acc[o] = acc[o] + SW'(prod_s1[o][t]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int o = 0; o < 4; o++) begin
			sum_s2[o] <= acc[o];
		end
	end

	// Stage 3: floor shift to the fraction point and clip to component range.
	always_comb begin
		for (int o = 0; o < 4; o++) begin
			shr[o] = RW'(sum_s2[o] >>> F);
			if (shr[o] > SMAX) begin
				ovf[o]  = 1'b1;
				satv[o] = SMAX[W-1:0];
			end else if (shr[o] < SMIN) begin
				ovf[o]  = 1'b1;
				satv[o] = SMIN[W-1:0];
			end else begin
				ovf[o]  = 1'b0;
				satv[o] = shr[o][W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		q_s3   <= satv;
		sat_s3 <= |ovf;
	end

	assign out_valid = v_s3;
	assign q         = q_s3;
	assign sat       = sat_s3;

endmodule

[design/quaternion_alu_with_rotation_top.sv]
// ----------------------------------------------------------------------------
// Quaternion ALU with rotation
// Multiply, add, subtract, conjugate and rotate on signed fixed-point
// quaternions, fully pipelined with saturation and a saturation flag.
// ----------------------------------------------------------------------------
//  Channel   Handshake           Signals
//  command   start, busy         operation, a_i, a_j, a_k, a_real,
//                                b_i, b_j, b_k, b_real
//  result    done (one cycle)    res_i, res_j, res_k, res_real, saturated
//
//  One command is taken in every cycle; busy is always low.
//  Every result passes through two 3-stage multipliers plus the output
//  register, whatever the operation.
//  Reset clears only the valid bits; commands in flight are dropped.
//  The result side cannot stall, so nothing in the pipeline ever holds.
// ----------------------------------------------------------------------------
`include "quaternion_alu_with_rotation_top_macros.svh"

module quaternion_alu_with_rotation_top #(
	parameter int COMPONENT_WIDTH = qar_pkg::COMPONENT_WIDTH_DEF,
	parameter int FRACTION_BITS   = qar_pkg::FRACTION_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  qar_pkg::op_t                      operation,
	input  logic signed [COMPONENT_WIDTH-1:0] a_i,
	input  logic signed [COMPONENT_WIDTH-1:0] a_j,
	input  logic signed [COMPONENT_WIDTH-1:0] a_k,
	input  logic signed [COMPONENT_WIDTH-1:0] a_real,
	input  logic signed [COMPONENT_WIDTH-1:0] b_i,
	input  logic signed [COMPONENT_WIDTH-1:0] b_j,
	input  logic signed [COMPONENT_WIDTH-1:0] b_k,
	input  logic signed [COMPONENT_WIDTH-1:0] b_real,
	output logic                              done,
	output logic signed [COMPONENT_WIDTH-1:0] res_i,
	output logic signed [COMPONENT_WIDTH-1:0] res_j,
	output logic signed [COMPONENT_WIDTH-1:0] res_k,
	output logic signed [COMPONENT_WIDTH-1:0] res_real,
	output logic                              saturated
);
	import qar_pkg::*;

	localparam int W = COMPONENT_WIDTH;
	localparam logic [W-1:0] CMAX = {1'b0, {(W - 1){1'b1}}};
	localparam logic [W-1:0] CMIN = {1'b1, {(W - 1){1'b0}}};

	// Clip a value one bit wider than a component.
	function automatic logic sat_ovf(input logic [W:0] x);
		return x[W] != x[W-1];
	endfunction

	function automatic logic [W-1:0] sat_val(input logic [W:0] x);
		if (x[W] != x[W-1]) begin
			return x[W] ? CMIN : CMAX;
		end
		return x[W-1:0];
	endfunction

	logic [3:0][W-1:0] a_vec, b_vec;
	logic [W:0]        sum_w [4];
	logic [W:0]        dif_w [4];
	logic [W:0]        neg_w [3];
	logic [3:0][W-1:0] conj_c;
	logic              conj_flag;
	logic [3:0][W-1:0] pre_res;
	logic              pre_flag;

	logic              m0_valid, m0_sat, m1_valid, m1_sat;
	logic [3:0][W-1:0] m0_q, m1_q;

	op_t               op_s1, op_s2, op_s3, op_s4, op_s5, op_s6;
	logic [3:0][W-1:0] res_s1, res_s2, res_s3, res_s4, res_s5, res_s6;
	logic              flg_s1, flg_s2, flg_s3, flg_s4, flg_s5, flg_s6;
	logic [3:0][W-1:0] c_s1, c_s2, c_s3;
	logic [3:0][W-1:0] res_s7;
	logic              flg_s7, done_s7;

	assign busy  = 1'b0;
	assign a_vec = {a_real, a_k, a_j, a_i};
	assign b_vec = {b_real, b_k, b_j, b_i};

	// Entry: component-wise add, subtract and the saturated conjugate of A.
	always_comb begin
		for (int n = 0; n < 4; n++) begin
			sum_w[n] = {a_vec[n][W-1], a_vec[n]} + {b_vec[n][W-1], b_vec[n]};
			dif_w[n] = {a_vec[n][W-1], a_vec[n]} - {b_vec[n][W-1], b_vec[n]};
		end
		conj_flag = 1'b0;
		for (int n = 0; n < 3; n++) begin
			neg_w[n]  = -{a_vec[n][W-1], a_vec[n]};
			conj_c[n] = sat_val(neg_w[n]);
			conj_flag = conj_flag | sat_ovf(neg_w[n]);
		end
		conj_c[3] = a_vec[3];
	end

	// Results that need no multiplier; rotation keeps only the conjugate flag.
	always_comb begin
		pre_res  = '0;
		pre_flag = 1'b0;
		case (operation)
			OP_ADD: begin
				for (int n = 0; n < 4; n++) begin
					pre_res[n] = sat_val(sum_w[n]);
					pre_flag   = pre_flag | sat_ovf(sum_w[n]);
				end
			end
			OP_SUB: begin
				for (int n = 0; n < 4; n++) begin
					pre_res[n] = sat_val(dif_w[n]);
					pre_flag   = pre_flag | sat_ovf(dif_w[n]);
				end
			end
			OP_CONJ: begin
				pre_res  = conj_c;
				pre_flag = conj_flag;
			end
			OP_ROT: begin
				pre_flag = conj_flag;
			end
			default: begin
				pre_res  = '0;
				pre_flag = 1'b0;
			end
		endcase
	end

	// First product A*B.
	qar_qmul #(.W(W), .F(FRACTION_BITS)) u_mul_ab (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.a         (a_vec),
		.b         (b_vec),
		.out_valid (m0_valid),
		.q         (m0_q),
		.sat       (m0_sat)
	);

	// Second product (A*B)*conj(A), used by rotation.
	qar_qmul #(.W(W), .F(FRACTION_BITS)) u_mul_pc (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (m0_valid),
		.a         (m0_q),
		.b         (c_s3),
		.out_valid (m1_valid),
		.q         (m1_q),
		.sat       (m1_sat)
	);

	// Side data alongside the multipliers; the plain product merges at stage 4.
	always_ff @(posedge clk) begin
		op_s1  <= operation;
		res_s1 <= pre_res;
		flg_s1 <= pre_flag;
		c_s1   <= conj_c;
		op_s2  <= op_s1;
		res_s2 <= res_s1;
		flg_s2 <= flg_s1;
		c_s2   <= c_s1;
		op_s3  <= op_s2;
		res_s3 <= res_s2;
		flg_s3 <= flg_s2;
		c_s3   <= c_s2;
		op_s4  <= op_s3;
		res_s4 <= (op_s3 == OP_MUL) ? m0_q : res_s3;
		flg_s4 <= flg_s3 | (m0_sat & ((op_s3 == OP_MUL) || (op_s3 == OP_ROT)));
		op_s5  <= op_s4;
		res_s5 <= res_s4;
		flg_s5 <= flg_s4;
		op_s6  <= op_s5;
		res_s6 <= res_s5;
		flg_s6 <= flg_s5;
	end

	// Output register: rotation takes the second product.
	always_ff @(posedge clk) begin
		if (op_s6 == OP_ROT) begin
			res_s7 <= m1_q;
			flg_s7 <= flg_s6 | m1_sat;
		end else begin
			res_s7 <= res_s6;
			flg_s7 <= flg_s6;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s7 <= 1'b0;
		end else begin
			done_s7 <= m1_valid;
		end
	end

	assign done      = done_s7;
	assign res_i     = res_s7[0];
	assign res_j     = res_s7[1];
	assign res_k     = res_s7[2];
	assign res_real  = res_s7[3];
	assign saturated = flg_s7;

	// The result strobe trails the first multiplier's output through the second multiplier and the output register.
	`QAR_ASSERT_SAME(a_latency, 1'b1, done == $past(m0_valid, 4), "result strobe out of step")

	// An undefined operation yields a zero result with a clear flag.
	`QAR_ASSERT_NEXT(a_undef_zero, (m1_valid && op_s6 != OP_MUL && op_s6 != OP_ADD && op_s6 != OP_SUB && op_s6 != OP_CONJ && op_s6 != OP_ROT), (res_i == '0 && res_j == '0 && res_k == '0 && res_real == '0 && !saturated), "undefined operation gave nonzero result")

	// A flag raised early in a rotation survives to the result.
	`QAR_ASSERT_NEXT(a_rot_flag, (m1_valid && op_s6 == OP_ROT && flg_s6), (done && saturated), "rotation lost its saturation flag")

endmodule
